>>> src/tgc_pkg.sv
// Touch gesture classifier: shared types, constants and register codes.
// No dependencies; used by the interfaces and by every module of the block.
package tgc_pkg;

   // width of the sample timestamp on the port, and of the internal time arithmetic
   localparam int NOW_WIDTH  = 32;
   localparam int TIME_WIDTH = 32;
   localparam int CFG_WIDTH  = 16;

   typedef logic [TIME_WIDTH-1:0] time_type;
   typedef logic [CFG_WIDTH-1:0]  cfg_word_type;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_LONG_PRESS = 1'b0,
      CSR_TAP_WINDOW = 1'b1
   } csr_index_type;

   localparam cfg_word_type LONG_PRESS_RESET = CFG_WIDTH'(1500);
   localparam cfg_word_type TAP_WINDOW_RESET = CFG_WIDTH'(300);

   // event codes
   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_SINGLE = 2'd1,
      EV_DOUBLE = 2'd2,
      EV_LONG   = 2'd3
   } event_type;

   // pending tap counts
   localparam logic [1:0] TAPS_NONE   = 2'd0;
   localparam logic [1:0] TAPS_ONE    = 2'd1;
   localparam logic [1:0] TAPS_DOUBLE = 2'd2;

   typedef struct packed {
      logic                 touch_level;
      logic [NOW_WIDTH-1:0] now_ms;
      logic                 clear;
   } item_type;

   typedef struct packed {
      cfg_word_type long_press_ms;
      cfg_word_type double_tap_window_ms;
   } cfg_type;

endpackage

>>> src/tgc_if.sv
// Touch gesture classifier: valid/ready channel interfaces for samples and events.
// Depends on tgc_pkg for the field widths and the event type.
interface tgc_req_if;
   logic                          valid;
   logic                          ready;
   logic                          touch_level;
   logic [tgc_pkg::NOW_WIDTH-1:0] now_ms;
   logic                          clear;

   modport source (output valid, touch_level, now_ms, clear, input ready);
   modport sink   (input valid, touch_level, now_ms, clear, output ready);
endinterface

interface tgc_rsp_if;
   logic               valid;
   logic               ready;
   tgc_pkg::event_type event_res;

   modport source (output valid, event_res, input ready);
   modport sink   (input valid, event_res, output ready);
endinterface

>>> src/tgc_csr.sv
// Touch gesture classifier: configuration registers (long press time, tap window).
// Depends on tgc_pkg for the register codes, widths and reset values.
module tgc_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  tgc_pkg::csr_index_type csr_index,
   input  tgc_pkg::cfg_word_type csr_wdata,
   output tgc_pkg::cfg_type      cfg
);

   tgc_pkg::cfg_type cfg_ff;
   tgc_pkg::cfg_type cfg_in;

   // decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            tgc_pkg::CSR_LONG_PRESS: cfg_in.long_press_ms        = csr_wdata;
            tgc_pkg::CSR_TAP_WINDOW: cfg_in.double_tap_window_ms = csr_wdata;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_ms        <= tgc_pkg::LONG_PRESS_RESET;
         cfg_ff.double_tap_window_ms <= tgc_pkg::TAP_WINDOW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> src/tgc_step.sv
// Touch gesture classifier: gesture state and the per-sample update and event poll.
// Depends on tgc_pkg for the item, configuration and event types.
module tgc_step (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  tgc_pkg::item_type  item,
   input  tgc_pkg::cfg_type   cfg,
   output tgc_pkg::event_type event_res
);

   logic               touch_ff,       touch_in;
   tgc_pkg::time_type  press_start_ff, press_start_in;
   tgc_pkg::time_type  last_tap_ff,    last_tap_in;
   logic [1:0]         pending_ff,     pending_in;
   logic               long_seen_ff,   long_seen_in;

   tgc_pkg::time_type  now_t, long_t, win_t;
   tgc_pkg::time_type  el_release, el_tap_prev, el_hold, el_tap;
   logic               rise, fall;
   tgc_pkg::time_type  press_mid, last_mid;
   logic [1:0]         pending_mid;
   logic               long_mid;

   assign now_t  = tgc_pkg::time_type'(item.now_ms);
   assign long_t = tgc_pkg::time_type'(cfg.long_press_ms);
   assign win_t  = tgc_pkg::time_type'(cfg.double_tap_window_ms);

   assign rise = item.touch_level & ~touch_ff;
   assign fall = ~item.touch_level & touch_ff;

   // wrapping time differences against the stored timestamps
   assign el_release  = now_t - press_start_ff;
   assign el_tap_prev = now_t - last_tap_ff;

   // sampling update: edge handling
   always_comb begin
      press_mid   = press_start_ff;
      last_mid    = last_tap_ff;
      pending_mid = pending_ff;
      long_mid    = long_seen_ff;
      if (rise) begin
         press_mid = now_t;
         long_mid  = 1'b0;
      end
      if (fall) begin
         priority if (el_release >= long_t) begin
            long_mid    = 1'b1;
            pending_mid = tgc_pkg::TAPS_NONE;
            last_mid    = '0;
         end else if (el_tap_prev < win_t) begin
            pending_mid = tgc_pkg::TAPS_DOUBLE;
            last_mid    = '0;
         end else begin
            pending_mid = tgc_pkg::TAPS_ONE;
            last_mid    = now_t;
         end
      end
   end

   assign el_hold = now_t - press_mid;
   assign el_tap  = now_t - last_mid;

   // event poll, then clear overrides everything and keeps the stored touch level
   always_comb begin
      touch_in       = item.touch_level;
      press_start_in = press_mid;
      last_tap_in    = last_mid;
      pending_in     = pending_mid;
      long_seen_in   = long_mid;
      event_res      = tgc_pkg::EV_NONE;
      priority if (item.touch_level && !long_mid && (el_hold >= long_t)) begin
         long_seen_in = 1'b1;
         event_res    = tgc_pkg::EV_LONG;
      end else if (pending_mid == tgc_pkg::TAPS_DOUBLE) begin
         pending_in = tgc_pkg::TAPS_NONE;
         event_res  = tgc_pkg::EV_DOUBLE;
      end else if ((pending_mid == tgc_pkg::TAPS_ONE) && (el_tap > win_t)) begin
         pending_in = tgc_pkg::TAPS_NONE;
         event_res  = tgc_pkg::EV_SINGLE;
      end else begin
         event_res = tgc_pkg::EV_NONE;
      end
      if (item.clear) begin
         touch_in       = touch_ff;
         press_start_in = '0;
         last_tap_in    = '0;
         pending_in     = tgc_pkg::TAPS_NONE;
         long_seen_in   = 1'b0;
         event_res      = tgc_pkg::EV_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         touch_ff       <= 1'b0;
         press_start_ff <= '0;
         last_tap_ff    <= '0;
         pending_ff     <= tgc_pkg::TAPS_NONE;
         long_seen_ff   <= 1'b0;
      end else if (fire) begin
         touch_ff       <= touch_in;
         press_start_ff <= press_start_in;
         last_tap_ff    <= last_tap_in;
         pending_ff     <= pending_in;
         long_seen_ff   <= long_seen_in;
      end
   end

endmodule

>>> src/touch_gesture_classifier.sv
// Touch gesture classifier top level: sample register, gesture step, event register.
// A sample is held in the sample register until the step runs; its event is then registered in the event register.
// Throughput: one sample per cycle; input stalls only once both item registers are held.
// Reset (synchronous, active high) clears the gesture state, empties both item
// registers and loads the register defaults (1500 ms long press, 300 ms window).
// Depends on tgc_pkg, tgc_if, tgc_csr and tgc_step.
module touch_gesture_classifier (
   input  logic                   clock,
   input  logic                   reset,
   tgc_req_if.sink                req_chan,
   tgc_rsp_if.source              rsp_chan,
   input  logic                   csr_we,
   input  tgc_pkg::csr_index_type csr_index,
   input  tgc_pkg::cfg_word_type  csr_wdata
);

   logic               in_valid_ff,  in_valid_in;
   tgc_pkg::item_type  in_item_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   tgc_pkg::event_type rsp_event_ff;
   tgc_pkg::event_type step_event;
   tgc_pkg::cfg_type   cfg;
   logic               out_free, step_fire, req_take;

   // handshake: the step runs when a sample is held and the event register is free or being emptied
   assign out_free       = ~rsp_valid_ff | rsp_chan.ready;
   assign step_fire      = in_valid_ff & out_free;
   assign req_chan.ready = ~in_valid_ff | out_free;
   assign req_take       = req_chan.valid & req_chan.ready;

   assign in_valid_in  = req_take | (in_valid_ff & ~step_fire);
   assign rsp_valid_in = step_fire | (rsp_valid_ff & ~rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.touch_level <= req_chan.touch_level;
         in_item_ff.now_ms      <= req_chan.now_ms;
         in_item_ff.clear       <= req_chan.clear;
      end
      if (step_fire) begin
         rsp_event_ff <= step_event;
      end
   end

   tgc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tgc_step u_step (
      .clock     (clock),
      .reset     (reset),
      .fire      (step_fire),
      .item      (in_item_ff),
      .cfg       (cfg),
      .event_res (step_event)
   );

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.event_res = rsp_event_ff;

`ifndef SYNTHESIS
   // a sample is never taken while the sample register is full and stuck
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(req_take && in_valid_ff && !out_free))
      else $error("sample accepted into a blocked sample register");

   // a clear sample always yields no event
   a_clear_none: assert property (@(posedge clock) disable iff (reset)
      step_fire && in_item_ff.clear |=> rsp_event_ff == tgc_pkg::EV_NONE)
      else $error("clear sample produced an event");

   // every step loads the event register
   a_step_loads: assert property (@(posedge clock) disable iff (reset)
      step_fire |=> rsp_valid_ff)
      else $error("event register not loaded after a step");

   // nothing is pending straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !in_valid_ff)
      else $error("item registers not empty after reset");
`endif

endmodule
